// ----- hw/rtl/ppd_pkg.sv -----
`default_nettype none

package ppd_pkg;

   // Fixed field widths
   localparam int GAIN_WIDTH     = 24;
   localparam int DEADBAND_WIDTH = 8;
   localparam int TICKS_WIDTH    = 16;
   localparam int DIR_WIDTH      = 2;
   localparam int MAG_WIDTH      = 16;
   localparam int CSR_IDX_WIDTH  = 8;
   localparam int CSR_DATA_WIDTH = 24;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PROP_GAIN  = 8'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_INTEG_GAIN = 8'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_DERIV_GAIN = 8'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_DEAD_BAND  = 8'd3;

   // Register reset values
   localparam logic [GAIN_WIDTH-1:0]     PROP_GAIN_RESET  = 24'd131072;
   localparam logic [GAIN_WIDTH-1:0]     INTEG_GAIN_RESET = 24'd13107;
   localparam logic [GAIN_WIDTH-1:0]     DERIV_GAIN_RESET = 24'd1311;
   localparam logic [DEADBAND_WIDTH-1:0] DEAD_BAND_RESET  = 8'd3;

   // Present drive direction codes
   localparam logic [DIR_WIDTH-1:0] DIR_FORWARD  = 2'd1;
   localparam logic [DIR_WIDTH-1:0] DIR_BACKWARD = 2'd2;

   // Number of partial products per sample (three terms, two halves each)
   localparam int MUL_STEPS = 6;

   typedef enum logic [1:0] {
      MOTOR_KEEP     = 2'd0,
      MOTOR_STOP     = 2'd1,
      MOTOR_FORWARD  = 2'd2,
      MOTOR_BACKWARD = 2'd3
   } motor_cmd_type;

   typedef enum logic [1:0] {
      TERM_PROP  = 2'd0,
      TERM_INTEG = 2'd1,
      TERM_DERIV = 2'd2
   } mul_term_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic         capture;
      logic         prep;
      logic         div_step;
      logic         slope;
      logic         mul_en;
      mul_term_type mul_term;
      logic         mul_hi;
      logic         acc_en;
      logic         load_out;
   } cmd_type;

endpackage

`default_nettype wire

// ----- hw/rtl/position_pid_with_direction_unit.sv -----
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  measured_position, target_position,
//                                            elapsed_ticks, drive_direction
// rsp      out        rsp_valid / rsp_stall  drive_magnitude, motor_command
// csr      in         csr_wen                csr_index, csr_wdata
//
// A new request is taken only after the previous sample has been loaded into
// the output register. The bit-serial divider (one quotient bit a cycle) and
// six partial products through one shared 25x17 multiplier set the sample time.
// Reset is synchronous: it restores the register defaults and clears the
// integral and the stored position. The result waits in an output register;
// while rsp_stall holds it, a finished sample waits until the register frees.

module position_pid_with_direction_unit #(
   parameter int POSITION_WIDTH = 24,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_valid,
   output logic                                      req_stall,
   input  wire  signed [POSITION_WIDTH-1:0]          req_measured_position,
   input  wire  signed [POSITION_WIDTH-1:0]          req_target_position,
   input  wire         [ppd_pkg::TICKS_WIDTH-1:0]    req_elapsed_ticks,
   input  wire         [ppd_pkg::DIR_WIDTH-1:0]      req_drive_direction,
   output logic                                      rsp_valid,
   input  wire                                       rsp_stall,
   output logic        [ppd_pkg::MAG_WIDTH-1:0]      rsp_drive_magnitude,
   output logic        [1:0]                         rsp_motor_command,
   input  wire                                       csr_wen,
   input  wire         [ppd_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire         [ppd_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   ppd_pkg::cmd_type cmd;

   // Sequence control
   ppd_ctrl #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Arithmetic, state and configuration
   ppd_datapath #(
      .POSITION_WIDTH(POSITION_WIDTH),
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .csr_wen               (csr_wen),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_measured_position (req_measured_position),
      .req_target_position   (req_target_position),
      .req_elapsed_ticks     (req_elapsed_ticks),
      .req_drive_direction   (req_drive_direction),
      .rsp_drive_magnitude   (rsp_drive_magnitude),
      .rsp_motor_command     (rsp_motor_command)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/ppd_ctrl.sv -----
`default_nettype none

module ppd_ctrl #(
   parameter int POSITION_WIDTH = 24
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output ppd_pkg::cmd_type cmd
);

   localparam int CNT_W = $clog2(POSITION_WIDTH + 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(POSITION_WIDTH - 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(ppd_pkg::MUL_STEPS);
   localparam logic [CNT_W-1:0] MUL_CUT  = CNT_W'(ppd_pkg::MUL_STEPS - 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_PREP   = 6'b000010,
      ST_DIV    = 6'b000100,
      ST_SLOPE  = 6'b001000,
      ST_MUL    = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Sequence one sample: prepare, divide, form slope, multiply, deliver
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.mul_term = ppd_pkg::mul_term_type'(cnt_ff[2:1]);
      cmd.mul_hi   = cnt_ff[0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_SLOPE;
            end
         end
         ST_SLOPE: begin
            cmd.slope = 1'b1;
            cnt_in    = '0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            // Product register feeds the accumulator in the following cycle
            cmd.mul_en = (cnt_ff <= MUL_CUT);
            cmd.acc_en = (cnt_ff != '0);
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ppd_datapath.sv -----
`default_nettype none

module ppd_datapath #(
   parameter int POSITION_WIDTH = 24,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  wire                                        clock,
   input  wire                                        reset,
   input  ppd_pkg::cmd_type                           cmd,
   input  wire                                        csr_wen,
   input  wire         [ppd_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  wire         [ppd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  wire  signed [POSITION_WIDTH-1:0]           req_measured_position,
   input  wire  signed [POSITION_WIDTH-1:0]           req_target_position,
   input  wire         [ppd_pkg::TICKS_WIDTH-1:0]     req_elapsed_ticks,
   input  wire         [ppd_pkg::DIR_WIDTH-1:0]       req_drive_direction,
   output logic        [ppd_pkg::MAG_WIDTH-1:0]       rsp_drive_magnitude,
   output logic        [1:0]                          rsp_motor_command
);

   localparam int PW      = POSITION_WIDTH;
   localparam int DW      = PW + 1;
   localparam int OP_W    = (DW > 32) ? DW : 32;
   localparam int PART_W  = OP_W - 16 + 1;
   localparam int PP_W    = ppd_pkg::GAIN_WIDTH + 1 + PART_W;
   localparam int ACC_W   = OP_W + 27;
   localparam int SUM_W   = OP_W + 2;
   localparam int TW      = ppd_pkg::TICKS_WIDTH;
   localparam int GW      = ppd_pkg::GAIN_WIDTH;
   localparam int MW      = ppd_pkg::MAG_WIDTH;

   localparam logic signed [SUM_W-1:0] ERR_MAX = (SUM_W'(1) <<< 31) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] ERR_MIN = -(SUM_W'(1) <<< 31);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (GAIN_FRAC_BITS - 1);

   // Configuration registers
   logic [GW-1:0]                         prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [ppd_pkg::DEADBAND_WIDTH-1:0]    dead_band_ff;

   // Loop state
   logic signed [31:0]                    err_sum_ff;
   logic signed [PW-1:0]                  prev_pos_ff;

   // Per-sample working registers
   logic signed [DW-1:0]                  delta_ff;
   logic signed [DW-1:0]                  change_ff;
   logic [TW-1:0]                         ticks_ff;
   logic [ppd_pkg::DIR_WIDTH-1:0]         dir_ff;
   logic                                  change_neg_ff;
   logic [PW-1:0]                         quot_ff;
   logic [TW-1:0]                         rem_ff;
   logic signed [OP_W-1:0]                slope_ff;
   logic signed [PP_W-1:0]                pp_ff;
   logic                                  pp_hi_ff;
   logic signed [ACC_W-1:0]               acc_ff;
   ppd_pkg::motor_cmd_type                motor_ff;
   logic [MW-1:0]                         mag_out_ff;
   ppd_pkg::motor_cmd_type                motor_out_ff;

   // Combinational helpers
   logic signed [SUM_W-1:0]               sum_raw;
   logic signed [SUM_W-1:0]               sum_sat;
   logic [DW-1:0]                         abs_delta;
   logic [DW-1:0]                         abs_change;
   ppd_pkg::motor_cmd_type                motor_next;
   logic [TW:0]                           trial;
   logic                                  trial_ok;
   logic [GW-1:0]                         mul_gain;
   logic signed [OP_W-1:0]                mul_op;
   logic signed [PART_W-1:0]              mul_part;
   logic signed [PP_W-1:0]                pp_next;
   logic signed [ACC_W-1:0]               pp_ext;
   logic [ACC_W-1:0]                      acc_abs;
   logic [ACC_W-1:0]                      acc_shift;
   logic [MW-1:0]                         mag_next;

   // Configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= ppd_pkg::PROP_GAIN_RESET;
         integ_gain_ff <= ppd_pkg::INTEG_GAIN_RESET;
         deriv_gain_ff <= ppd_pkg::DERIV_GAIN_RESET;
         dead_band_ff  <= ppd_pkg::DEAD_BAND_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            ppd_pkg::REG_PROP_GAIN:  prop_gain_ff  <= csr_wdata[GW-1:0];
            ppd_pkg::REG_INTEG_GAIN: integ_gain_ff <= csr_wdata[GW-1:0];
            ppd_pkg::REG_DERIV_GAIN: deriv_gain_ff <= csr_wdata[GW-1:0];
            ppd_pkg::REG_DEAD_BAND:  dead_band_ff  <= csr_wdata[ppd_pkg::DEADBAND_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Saturating integral update and motor command
   always_comb begin
      sum_raw = SUM_W'(err_sum_ff) + SUM_W'(delta_ff);
      if (sum_raw > ERR_MAX) begin
         sum_sat = ERR_MAX;
      end else if (sum_raw < ERR_MIN) begin
         sum_sat = ERR_MIN;
      end else begin
         sum_sat = sum_raw;
      end
      abs_delta  = delta_ff[DW-1] ? DW'(-delta_ff) : DW'(delta_ff);
      abs_change = change_ff[DW-1] ? DW'(-change_ff) : DW'(change_ff);
      priority if (abs_delta <= DW'(dead_band_ff)) begin
         motor_next = ppd_pkg::MOTOR_STOP;
      end else if (dir_ff == ppd_pkg::DIR_FORWARD) begin
         motor_next = delta_ff[DW-1] ? ppd_pkg::MOTOR_BACKWARD : ppd_pkg::MOTOR_KEEP;
      end else if (dir_ff == ppd_pkg::DIR_BACKWARD) begin
         motor_next = delta_ff[DW-1] ? ppd_pkg::MOTOR_KEEP : ppd_pkg::MOTOR_FORWARD;
      end else begin
         motor_next = ppd_pkg::MOTOR_FORWARD;
      end
   end

   // One restoring division step: bring down the next dividend bit
   assign trial    = {rem_ff, quot_ff[PW-1]};
   assign trial_ok = (trial >= {1'b0, ticks_ff});

   // Select one gain and one 16-bit half of its operand
   always_comb begin
      unique case (cmd.mul_term)
         ppd_pkg::TERM_PROP: begin
            mul_gain = prop_gain_ff;
            mul_op   = OP_W'(delta_ff);
         end
         ppd_pkg::TERM_INTEG: begin
            mul_gain = integ_gain_ff;
            mul_op   = OP_W'(err_sum_ff);
         end
         ppd_pkg::TERM_DERIV: begin
            mul_gain = deriv_gain_ff;
            mul_op   = slope_ff;
         end
         default: begin
            mul_gain = '0;
            mul_op   = '0;
         end
      endcase
      if (cmd.mul_hi) begin
         mul_part = PART_W'($signed(mul_op[OP_W-1:16]));
      end else begin
         mul_part = $signed(PART_W'(mul_op[15:0]));
      end
      pp_next = $signed({1'b0, mul_gain}) * mul_part;
      pp_ext  = pp_hi_ff ? (ACC_W'(pp_ff) <<< 16) : ACC_W'(pp_ff);
   end

   // Magnitude of the rounded sum, saturated
   always_comb begin
      acc_abs   = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      acc_shift = acc_abs >> GAIN_FRAC_BITS;
      mag_next  = (|acc_shift[ACC_W-1:MW]) ? {MW{1'b1}} : acc_shift[MW-1:0];
   end

   // Loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         err_sum_ff  <= '0;
         prev_pos_ff <= '0;
      end else begin
         if (cmd.capture) begin
            prev_pos_ff <= req_measured_position;
         end
         if (cmd.prep) begin
            err_sum_ff <= sum_sat[31:0];
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         delta_ff  <= DW'(req_target_position) - DW'(req_measured_position);
         change_ff <= DW'(req_measured_position) - DW'(prev_pos_ff);
         ticks_ff  <= req_elapsed_ticks;
         dir_ff    <= req_drive_direction;
      end
      if (cmd.prep) begin
         change_neg_ff <= change_ff[DW-1];
         quot_ff       <= abs_change[PW-1:0];
         rem_ff        <= '0;
         motor_ff      <= motor_next;
         acc_ff        <= ROUND_HALF;
      end
      if (cmd.div_step) begin
         rem_ff  <= trial_ok ? TW'(trial - {1'b0, ticks_ff}) : trial[TW-1:0];
         quot_ff <= {quot_ff[PW-2:0], trial_ok};
      end
      if (cmd.slope) begin
         if (ticks_ff == '0) begin
            slope_ff <= '0;
         end else if (change_neg_ff) begin
            slope_ff <= -$signed(OP_W'(quot_ff));
         end else begin
            slope_ff <= $signed(OP_W'(quot_ff));
         end
      end
      if (cmd.mul_en) begin
         pp_ff    <= pp_next;
         pp_hi_ff <= cmd.mul_hi;
      end
      if (cmd.acc_en) begin
         acc_ff <= acc_ff + pp_ext;
      end
      if (cmd.load_out) begin
         mag_out_ff   <= mag_next;
         motor_out_ff <= motor_ff;
      end
   end

   assign rsp_drive_magnitude = mag_out_ff;
   assign rsp_motor_command   = motor_out_ff;

endmodule

`default_nettype wire
